@@ src/ppgbr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppgbr_pkg: shared definitions for the pulse beat rate detector
// Payload types, field widths, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package ppgbr_pkg;

  // Samples per evaluation group.
  localparam int GROUP_SIZE = 8;
  localparam int SLOT_W     = $clog2(GROUP_SIZE);

  localparam int LEVEL_W  = 18;
  localparam int TICK_W   = 32;
  localparam int IDX_W    = 16;
  localparam int PERIOD_W = 8;
  localparam int THR_W    = 19;
  localparam int LOW_W    = 22;
  localparam int IVAL_W   = 16;
  localparam int RATE_W   = 8;

  // Sum of up to GROUP_SIZE-1 signed level differences.
  localparam int SUM_W = LEVEL_W + 1 + SLOT_W;
  // Width for the scaled threshold compare.
  localparam int LIM_W = SUM_W + 2;

  localparam logic [LOW_W-1:0] LEVEL_IDLE_LOW = LOW_W'(4000000);
  localparam logic [IDX_W-1:0] COUNT_MAX      = '1;

  // Shared divider: quotient of RATE_NUM by a divisor, saturated.
  localparam int RATE_NUM = 60000;
  localparam int RATE_MAX = 255;
  localparam int Q_W      = RATE_W;
  localparam int STEP_W   = $clog2(Q_W);
  localparam int REM_W    = 16;
  localparam int DIV_W    = PERIOD_W + IDX_W;
  localparam int DSH_W    = DIV_W + Q_W - 1;
  localparam int SAT_DIV  = RATE_NUM / (RATE_MAX + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_SLOPE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_LVL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SEARCH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd3;

  localparam logic signed [THR_W-1:0] THR_RESET      = -19'sd50;
  localparam logic [LEVEL_W-1:0]      PRESENCE_RESET = 18'd5000;
  localparam logic [IDX_W-1:0]        LIMIT_RESET    = 16'd50;
  localparam logic [PERIOD_W-1:0]     PERIOD_RESET   = 8'd10;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_value;
    logic [TICK_W-1:0]  tick_ms;
    logic               sample_valid;
  } ppgbr_in_t;

  typedef struct packed {
    logic [RATE_W-1:0]        rate_by_time;
    logic [RATE_W-1:0]        rate_by_count;
    logic signed [IVAL_W-1:0] interval_ms;
    logic [IVAL_W-1:0]        interval_samples;
    logic                     interval_bad;
  } ppgbr_out_t;

endpackage

@@ src/ppgbr_div.sv @@
// ----------------------------------------------------------------------------
// ppgbr_div: shared restoring divider for beat rates
// Computes RATE_NUM / divisor, saturated to RATE_MAX, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppgbr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppgbr_pkg::DIV_W-1:0]   divisor,
  output logic                          done,
  output logic [ppgbr_pkg::Q_W-1:0]     quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [ppgbr_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [ppgbr_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [ppgbr_pkg::DSH_W-1:0]     dsh_r, dsh_nxt;
  logic [ppgbr_pkg::Q_W-1:0]       q_r, q_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    priority if (start) begin
      // Small divisors give a quotient past the top, so no iteration is needed.
      if (divisor <= ppgbr_pkg::DIV_W'(ppgbr_pkg::SAT_DIV)) begin
        q_nxt    = ppgbr_pkg::Q_W'(ppgbr_pkg::RATE_MAX);
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        rem_nxt  = ppgbr_pkg::REM_W'(ppgbr_pkg::RATE_NUM);
        dsh_nxt  = ppgbr_pkg::DSH_W'(divisor) << (ppgbr_pkg::Q_W - 1);
        cnt_nxt  = '0;
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      if (ppgbr_pkg::DSH_W'(rem_r) >= dsh_r) begin
        rem_nxt = rem_r - ppgbr_pkg::REM_W'(dsh_r);
        q_nxt   = {q_r[ppgbr_pkg::Q_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[ppgbr_pkg::Q_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ppgbr_pkg::STEP_W'(ppgbr_pkg::Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r == ppgbr_pkg::STEP_W'(ppgbr_pkg::Q_W - 1)) |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(start))
    else $error("divider done held without a new request");

endmodule

@@ src/ppg_beat_rate_detector.sv @@
// A sample that does not close a group leaves the input ready, and the next one
// may follow right after. A group end without a beat stalls the input for the
// group evaluation. A group end with a beat stalls it through evaluation, multiply,
// a shared-divider divide per rate (none for a bad interval) and hand-off.
// The input stays stalled longer while a finished beat waits for a held output.
// Reset (rst_n, synchronous, active low) restores register defaults at once.
// ----------------------------------------------------------------------------
// ppg_beat_rate_detector: optical pulse beat rate detector
// Tracks run extremes, evaluates the mean slope of each sample group and
// reports beat rates from the peak interval through a shared divider.
// ----------------------------------------------------------------------------
module ppg_beat_rate_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ppgbr_pkg::ppgbr_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ppgbr_pkg::ppgbr_out_t               out_data,
  input  logic                                cfg_we,
  input  logic [ppgbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppgbr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIVT  = 3'd3;
  localparam logic [2:0] ST_WAITT = 3'd4;
  localparam logic [2:0] ST_DIVC  = 3'd5;
  localparam logic [2:0] ST_WAITC = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic signed [ppgbr_pkg::LIM_W-1:0] GRP_S =
    ppgbr_pkg::LIM_W'(ppgbr_pkg::GROUP_SIZE);
  localparam logic signed [ppgbr_pkg::LIM_W-1:0] ONE_S = ppgbr_pkg::LIM_W'(1);

  // Configuration registers.
  logic signed [ppgbr_pkg::THR_W-1:0]   thr_r;
  logic [ppgbr_pkg::LEVEL_W-1:0]        presence_r;
  logic [ppgbr_pkg::IDX_W-1:0]          limit_r;
  logic [ppgbr_pkg::PERIOD_W-1:0]       period_r;

  // Run and group state.
  logic [2:0]                           state_r, state_nxt;
  logic [ppgbr_pkg::LEVEL_W-1:0]        prev_r, prev_nxt;
  logic [ppgbr_pkg::SLOT_W-1:0]         slot_r, slot_nxt;
  logic signed [ppgbr_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [ppgbr_pkg::LOW_W-1:0]          gmin_r, gmin_nxt;
  logic [ppgbr_pkg::LOW_W-1:0]          low_lvl_r, low_lvl_nxt;
  logic [ppgbr_pkg::TICK_W-1:0]         low_time_r, low_time_nxt;
  logic [ppgbr_pkg::IDX_W-1:0]          low_idx_r, low_idx_nxt;
  logic [ppgbr_pkg::LEVEL_W-1:0]        high_lvl_r, high_lvl_nxt;
  logic [ppgbr_pkg::TICK_W-1:0]         high_time_r, high_time_nxt;
  logic [ppgbr_pkg::IDX_W-1:0]          high_idx_r, high_idx_nxt;
  logic [ppgbr_pkg::IDX_W-1:0]          run_cnt_r, run_cnt_nxt;
  logic                                 falling_r, falling_nxt;

  // Beat result under construction.
  logic signed [ppgbr_pkg::IVAL_W-1:0]  dt_r, dt_nxt;
  logic [ppgbr_pkg::IVAL_W-1:0]         ds_r, ds_nxt;
  logic                                 tbad_r, tbad_nxt;
  logic                                 cbad_r, cbad_nxt;
  logic [ppgbr_pkg::DIV_W-1:0]          prod_r, prod_nxt;
  logic [ppgbr_pkg::RATE_W-1:0]         rt_r, rt_nxt;
  logic [ppgbr_pkg::RATE_W-1:0]         rc_r, rc_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  ppgbr_pkg::ppgbr_out_t                out_data_r, out_data_nxt;

  logic                                 accept;
  logic                                 div_start;
  logic [ppgbr_pkg::DIV_W-1:0]          div_divisor;
  logic                                 div_done;
  logic [ppgbr_pkg::Q_W-1:0]            div_q;

  logic signed [ppgbr_pkg::LIM_W-1:0]   thr_ext;
  logic signed [ppgbr_pkg::LIM_W-1:0]   sum_ext;
  logic signed [ppgbr_pkg::LIM_W-1:0]   slope_lim;
  logic                                 present;
  logic                                 slope_low;
  logic                                 slope_pos;
  logic                                 beat;
  logic [ppgbr_pkg::IVAL_W-1:0]         dt_raw;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // The mean slope is truncated toward zero, so compare the raw sum against
  // the threshold scaled by the group size instead of dividing.
  assign thr_ext   = ppgbr_pkg::LIM_W'(thr_r);
  assign sum_ext   = ppgbr_pkg::LIM_W'(sum_r);
  assign slope_lim = (thr_ext >= ONE_S) ? GRP_S * thr_ext
                                        : GRP_S * (thr_ext - ONE_S) + ONE_S;
  assign slope_low = sum_ext < slope_lim;
  assign slope_pos = sum_ext >= GRP_S;
  assign present   = gmin_r >= ppgbr_pkg::LOW_W'(presence_r);
  assign beat      = present && slope_low && !falling_r;
  assign dt_raw    = ppgbr_pkg::IVAL_W'(high_time_r - low_time_r);

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    gmin_nxt      = gmin_r;
    low_lvl_nxt   = low_lvl_r;
    low_time_nxt  = low_time_r;
    low_idx_nxt   = low_idx_r;
    high_lvl_nxt  = high_lvl_r;
    high_time_nxt = high_time_r;
    high_idx_nxt  = high_idx_r;
    run_cnt_nxt   = run_cnt_r;
    falling_nxt   = falling_r;
    dt_nxt        = dt_r;
    ds_nxt        = ds_r;
    tbad_nxt      = tbad_r;
    cbad_nxt      = cbad_r;
    prod_nxt      = prod_r;
    rt_nxt        = rt_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_divisor   = prod_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.sample_valid) begin
            if ((run_cnt_r < limit_r) &&
                (low_lvl_r > ppgbr_pkg::LOW_W'(in_data.red_value))) begin
              low_lvl_nxt  = ppgbr_pkg::LOW_W'(in_data.red_value);
              low_time_nxt = in_data.tick_ms;
              low_idx_nxt  = run_cnt_r;
            end
            if (high_lvl_r < in_data.red_value) begin
              high_lvl_nxt  = in_data.red_value;
              high_time_nxt = in_data.tick_ms;
              high_idx_nxt  = run_cnt_r;
            end
            if (gmin_r > ppgbr_pkg::LOW_W'(in_data.red_value)) begin
              gmin_nxt = ppgbr_pkg::LOW_W'(in_data.red_value);
            end
            if (run_cnt_r != ppgbr_pkg::COUNT_MAX) begin
              run_cnt_nxt = run_cnt_r + 1'b1;
            end
            if (slot_r != '0) begin
              sum_nxt = sum_r
                      + ppgbr_pkg::SUM_W'($signed({1'b0, in_data.red_value}))
                      - ppgbr_pkg::SUM_W'($signed({1'b0, prev_r}));
            end
            prev_nxt = in_data.red_value;
          end
          if (slot_r == ppgbr_pkg::SLOT_W'(ppgbr_pkg::GROUP_SIZE - 1)) begin
            slot_nxt  = '0;
            state_nxt = ST_EVAL;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        if (beat) begin
          dt_nxt       = $signed(dt_raw);
          ds_nxt       = high_idx_r - low_idx_r;
          tbad_nxt     = dt_raw[ppgbr_pkg::IVAL_W-1] || (dt_raw == '0);
          cbad_nxt     = high_idx_r <= low_idx_r;
          low_lvl_nxt  = ppgbr_pkg::LEVEL_IDLE_LOW;
          high_lvl_nxt = '0;
          low_idx_nxt  = '0;
          high_idx_nxt = '0;
          run_cnt_nxt  = '0;
          state_nxt    = ST_MUL;
        end
        // A rising group clears the mark even in the group that set it.
        if (present && slope_pos) begin
          falling_nxt = 1'b0;
        end else if (beat) begin
          falling_nxt = 1'b1;
        end
        sum_nxt  = '0;
        gmin_nxt = ppgbr_pkg::LEVEL_IDLE_LOW;
      end
      ST_MUL: begin
        prod_nxt  = ppgbr_pkg::DIV_W'(period_r) * ppgbr_pkg::DIV_W'(ds_r);
        state_nxt = ST_DIVT;
      end
      ST_DIVT: begin
        if (tbad_r) begin
          rt_nxt    = '0;
          state_nxt = ST_DIVC;
        end else begin
          div_start   = 1'b1;
          div_divisor = ppgbr_pkg::DIV_W'($unsigned(dt_r));
          state_nxt   = ST_WAITT;
        end
      end
      ST_WAITT: begin
        if (div_done) begin
          rt_nxt    = div_q;
          state_nxt = ST_DIVC;
        end
      end
      ST_DIVC: begin
        if (cbad_r) begin
          rc_nxt    = '0;
          state_nxt = ST_OUT;
        end else begin
          div_start   = 1'b1;
          div_divisor = prod_r;
          state_nxt   = ST_WAITC;
        end
      end
      ST_WAITC: begin
        if (div_done) begin
          rc_nxt    = div_q;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.rate_by_time     = rt_r;
          out_data_nxt.rate_by_count    = rc_r;
          out_data_nxt.interval_ms      = dt_r;
          out_data_nxt.interval_samples = ds_r;
          out_data_nxt.interval_bad     = tbad_r || cbad_r;
          state_nxt                     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  ppgbr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= ppgbr_pkg::THR_RESET;
      presence_r <= ppgbr_pkg::PRESENCE_RESET;
      limit_r    <= ppgbr_pkg::LIMIT_RESET;
      period_r   <= ppgbr_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppgbr_pkg::CFG_NEG_SLOPE_THR: thr_r      <= $signed(cfg_wdata);
        ppgbr_pkg::CFG_PRESENCE_LVL:  presence_r <= cfg_wdata[ppgbr_pkg::LEVEL_W-1:0];
        ppgbr_pkg::CFG_LOW_SEARCH:    limit_r    <= cfg_wdata[ppgbr_pkg::IDX_W-1:0];
        ppgbr_pkg::CFG_SAMPLE_PERIOD: period_r   <= cfg_wdata[ppgbr_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      gmin_r      <= ppgbr_pkg::LEVEL_IDLE_LOW;
      low_lvl_r   <= ppgbr_pkg::LEVEL_IDLE_LOW;
      low_time_r  <= '0;
      low_idx_r   <= '0;
      high_lvl_r  <= '0;
      high_time_r <= '0;
      high_idx_r  <= '0;
      run_cnt_r   <= '0;
      falling_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      gmin_r      <= gmin_nxt;
      low_lvl_r   <= low_lvl_nxt;
      low_time_r  <= low_time_nxt;
      low_idx_r   <= low_idx_nxt;
      high_lvl_r  <= high_lvl_nxt;
      high_time_r <= high_time_nxt;
      high_idx_r  <= high_idx_nxt;
      run_cnt_r   <= run_cnt_nxt;
      falling_r   <= falling_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dt_r       <= dt_nxt;
    ds_r       <= ds_nxt;
    tbad_r     <= tbad_nxt;
    cbad_r     <= cbad_nxt;
    prod_r     <= prod_nxt;
    rt_r       <= rt_nxt;
    rc_r       <= rc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAITT) || (state_r == ST_WAITC))
    else $error("divider result arrived outside a wait state");

  a_beat_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && beat |=> (run_cnt_r == '0) && (state_r == ST_MUL))
    else $error("beat did not clear the run");

  a_falling_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(falling_r) |-> $past(state_r) == ST_EVAL)
    else $error("falling mark set outside group evaluation");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && (!out_valid_r || !out_stall) |=> out_valid_r
      && (state_r == ST_IDLE))
    else $error("beat result was not delivered to the output register");

endmodule
